// ===== hw/rtl/sha1md_pkg.sv =====
package sha1md_pkg;

   // Initial chaining values h0..h4
   localparam logic [31:0] H0_INIT = 32'h6745_2301;
   localparam logic [31:0] H1_INIT = 32'hefcd_ab89;
   localparam logic [31:0] H2_INIT = 32'h98ba_dcfe;
   localparam logic [31:0] H3_INIT = 32'h1032_5476;
   localparam logic [31:0] H4_INIT = 32'hc3d2_e1f0;

   // Round constants, one per group of 20 rounds
   localparam logic [31:0] K_ROUND_0 = 32'h5A82_7999;
   localparam logic [31:0] K_ROUND_1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K_ROUND_2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K_ROUND_3 = 32'hCA62_C1D6;

   localparam int unsigned ROUND_W   = 7;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
   localparam logic [ROUND_W-1:0] ROUND_ADD  = 7'd80;

   // Working state of the block: five 32-bit chaining words
   typedef logic [4:0][31:0] chain_type;

   // Commands from the sequencer to the compression engine
   typedef struct packed {
      logic       shift_en;
      logic [7:0] shift_byte;
      logic       start;
      logic       init;
   } ctrl_type;

   // Boolean function of round group
   function automatic logic [31:0] round_f(input logic [ROUND_W-1:0] round,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      logic [31:0] res;
      if (round < 7'd20) begin
         res = d ^ (b & (c ^ d));
      end else if (round < 7'd40) begin
         res = b ^ c ^ d;
      end else if (round < 7'd60) begin
         res = (b & c) | (d & (b | c));
      end else begin
         res = b ^ c ^ d;
      end
      return res;
   endfunction

   function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] round);
      logic [31:0] res;
      if (round < 7'd20) begin
         res = K_ROUND_0;
      end else if (round < 7'd40) begin
         res = K_ROUND_1;
      end else if (round < 7'd60) begin
         res = K_ROUND_2;
      end else begin
         res = K_ROUND_3;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/sha1md_engine.sv =====
module sha1md_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  sha1md_pkg::ctrl_type ctrl,
   output logic                 busy,
   output sha1md_pkg::chain_type chain
);
   import sha1md_pkg::*;

   // 16-word window: bytes shift in during fill, words shift through during rounds
   logic [511:0]        window_ff;
   logic [31:0]         a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [ROUND_W-1:0]  round_ff;
   logic                run_ff;
   chain_type           chain_ff;

   logic [31:0] w_cur;
   logic [31:0] w_mix;
   logic [31:0] w_new;
   logic [31:0] temp_in;

   // Schedule: W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
   assign w_cur = window_ff[511:480];
   assign w_mix = window_ff[95:64] ^ window_ff[255:224] ^ window_ff[447:416] ^ w_cur;
   assign w_new = {w_mix[30:0], w_mix[31]};

   // One round of the shared adder
   assign temp_in = {a_ff[26:0], a_ff[31:27]} + round_f(round_ff, b_ff, c_ff, d_ff)
                    + e_ff + round_k(round_ff) + w_cur;

   // Control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         round_ff <= '0;
         chain_ff <= {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};
      end else begin
         if (ctrl.init) begin
            chain_ff <= {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};
         end
         if (ctrl.start) begin
            run_ff   <= 1'b1;
            round_ff <= '0;
         end else if (run_ff) begin
            if (round_ff == ROUND_ADD) begin
               // feed-forward add closes the block
               run_ff      <= 1'b0;
               chain_ff[0] <= chain_ff[0] + a_ff;
               chain_ff[1] <= chain_ff[1] + b_ff;
               chain_ff[2] <= chain_ff[2] + c_ff;
               chain_ff[3] <= chain_ff[3] + d_ff;
               chain_ff[4] <= chain_ff[4] + e_ff;
            end else begin
               round_ff <= round_ff + 1'b1;
            end
         end
      end
   end

   // Window and working variables
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         window_ff <= {window_ff[503:0], ctrl.shift_byte};
      end else if (run_ff && (round_ff <= ROUND_LAST)) begin
         window_ff <= {window_ff[479:0], w_new};
      end
      if (ctrl.start) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (run_ff && (round_ff <= ROUND_LAST)) begin
         a_ff <= temp_in;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   assign busy  = run_ff;
   assign chain = chain_ff;

endmodule

// ===== hw/rtl/sha1_message_digest.sv =====
// SHA-1 hasher taking one message byte per transfer. In the idle state each
// transfer is taken (req_stall is low); the 64th byte of a block starts the
// shared round adder, which runs 80 rounds plus one feed-forward add; req_stall
// stays high until the block is back in idle, so no bytes are taken while a
// block is compressed. A transfer with end_of_message then pads the message:
// the 0x80 marker, zero bytes and the 64-bit length, with an extra block when
// 56 or more bytes are buffered, runs the one or two compressions, and delivers
// the digest words h0..h4 one per transfer (held while rsp_stall is high).
// The block then returns to its initial state.
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1md_pkg::*;

   localparam logic [6:0] FILL_LEN_START = 7'd56;
   localparam logic [6:0] FILL_LAST      = 7'd63;
   localparam logic [6:0] FILL_FULL      = 7'd64;
   localparam logic [7:0] PAD_MARK       = 8'h80;
   localparam logic [2:0] WORD_LAST      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLOCK_WAIT,
      ST_MARK,
      ST_ZERO,
      ST_PAD_WAIT,
      ST_LEN,
      ST_FINAL_WAIT,
      ST_OUT
   } state_type;

   state_type   state_ff;
   logic [6:0]  fill_ff;
   logic [63:0] bit_len_ff;
   logic [2:0]  word_idx_ff;
   logic        finish_ff;

   ctrl_type    ctrl;
   logic        busy;
   chain_type   chain;
   logic        req_xfer;

   sha1md_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .busy  (busy),
      .chain (chain)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain[word_idx_ff];
   assign rsp_word_index  = word_idx_ff;
   assign rsp_last_word   = (word_idx_ff == WORD_LAST);

   // Engine commands
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.shift_en   = req_xfer && req_byte_valid;
            ctrl.shift_byte = req_data_byte;
            ctrl.start      = req_xfer && req_byte_valid && (fill_ff == FILL_LAST);
         end
         ST_MARK: begin
            ctrl.shift_en   = 1'b1;
            ctrl.shift_byte = PAD_MARK;
         end
         ST_ZERO: begin
            if (fill_ff == FILL_FULL) begin
               ctrl.start = 1'b1;
            end else if (fill_ff != FILL_LEN_START) begin
               ctrl.shift_en = 1'b1;
            end
         end
         ST_LEN: begin
            ctrl.shift_en   = 1'b1;
            ctrl.shift_byte = bit_len_ff[63:56];
            ctrl.start      = (fill_ff == FILL_LAST);
         end
         ST_OUT: begin
            ctrl.init = !rsp_stall && (word_idx_ff == WORD_LAST);
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // Sequencer: fill, pad, length, digest delivery
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         bit_len_ff  <= '0;
         word_idx_ff <= '0;
         finish_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_byte_valid) begin
                     bit_len_ff <= bit_len_ff + 64'd8;
                     if (fill_ff == FILL_LAST) begin
                        fill_ff   <= '0;
                        finish_ff <= req_end_of_message;
                        state_ff  <= ST_BLOCK_WAIT;
                     end else begin
                        fill_ff <= fill_ff + 1'b1;
                        if (req_end_of_message) begin
                           state_ff <= ST_MARK;
                        end
                     end
                  end else if (req_end_of_message) begin
                     state_ff <= ST_MARK;
                  end
               end
            end
            ST_BLOCK_WAIT: begin
               if (!busy) begin
                  finish_ff <= 1'b0;
                  state_ff  <= finish_ff ? ST_MARK : ST_IDLE;
               end
            end
            ST_MARK: begin
               fill_ff  <= fill_ff + 1'b1;
               state_ff <= ST_ZERO;
            end
            ST_ZERO: begin
               if (fill_ff == FILL_LEN_START) begin
                  state_ff <= ST_LEN;
               end else if (fill_ff == FILL_FULL) begin
                  // marker did not leave room for the length: extra block
                  fill_ff  <= '0;
                  state_ff <= ST_PAD_WAIT;
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
            ST_PAD_WAIT: begin
               if (!busy) begin
                  state_ff <= ST_ZERO;
               end
            end
            ST_LEN: begin
               // length goes out big-endian; the counter ends up cleared
               bit_len_ff <= {bit_len_ff[55:0], 8'h00};
               if (fill_ff == FILL_LAST) begin
                  fill_ff  <= '0;
                  state_ff <= ST_FINAL_WAIT;
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
            ST_FINAL_WAIT: begin
               if (!busy) begin
                  word_idx_ff <= '0;
                  state_ff    <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  if (word_idx_ff == WORD_LAST) begin
                     word_idx_ff <= '0;
                     state_ff    <= ST_IDLE;
                  end else begin
                     word_idx_ff <= word_idx_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
